FILE: hdl/lookup2_block_hash_top_macros.svh
// assertion macros used by the final stage of the lookup2 block hash rtl
`ifndef LOOKUP2_BLOCK_HASH_TOP_MACROS_SVH
`define LOOKUP2_BLOCK_HASH_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// property checked at every clock edge outside reset
`define L2BH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies another in the next cycle
`define L2BH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define L2BH_ASSERT(lbl, prop, msg)
`define L2BH_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hdl/l2bh_pkg.sv
// types, constants and mixing functions of the lookup2 block hash
package l2bh_pkg;

    localparam logic [31:0] GOLDEN_RATIO = 32'h9e37_79b9;
    localparam logic [3:0]  BLOCK_BYTES  = 4'd12;
    localparam logic [31:0] BLOCK_LEN    = 32'd12;

    // the three hash accumulators
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } abc_t;

    // lookup2 mix of the three accumulators
    function automatic abc_t mix3(input abc_t s);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        abc_t        r;
        a = s.a;
        b = s.b;
        c = s.c;
        a = a - b - c; a = a ^ (c >> 13);
        b = b - c - a; b = b ^ (a << 8);
        c = c - a - b; c = c ^ (b >> 13);
        a = a - b - c; a = a ^ (c >> 12);
        b = b - c - a; b = b ^ (a << 16);
        c = c - a - b; c = c ^ (b >> 5);
        a = a - b - c; a = a ^ (c >> 3);
        b = b - c - a; b = b ^ (a << 10);
        c = c - a - b; c = c ^ (b >> 15);
        r.a = a;
        r.b = b;
        r.c = c;
        return r;
    endfunction

    // mask of the tail bytes that fall in the word starting at byte lo
    function automatic logic [31:0] lane_mask(input logic [3:0] n, input logic [3:0] lo);
        logic [31:0] m;
        if (n <= lo)
        begin
            m = 32'h0000_0000;
        end
        else if (n >= 4'(lo + 4'd4))
        begin
            m = 32'hffff_ffff;
        end
        else
        begin
            case (4'(n - lo))
                4'd1:    m = 32'h0000_00ff;
                4'd2:    m = 32'h0000_ffff;
                4'd3:    m = 32'h00ff_ffff;
                default: m = 32'hffff_ffff;
            endcase
        end
        return m;
    endfunction

endpackage

FILE: hdl/l2bh_absorb.sv
// input register, block accumulators and tail absorption
module l2bh_absorb
    import l2bh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] word0,
    input  logic [31:0] word1,
    input  logic [31:0] word2,
    input  logic [3:0]  byte_count,
    input  logic        last,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] seed,
    output logic        fin_valid,
    output abc_t        fin_data,
    input  logic        fin_ready
);

    logic        vld_reg;
    logic [31:0] w0_reg;
    logic [31:0] w1_reg;
    logic [31:0] w2_reg;
    logic [3:0]  cnt_reg;
    logic        last_reg;
    logic        in_key_reg;
    logic        in_key_next;
    abc_t        acc_reg;
    abc_t        acc_next;
    logic [31:0] len_reg;
    logic [31:0] len_next;

    abc_t        base;
    logic [31:0] base_len;
    abc_t        sum;
    abc_t        mixed;
    logic [3:0]  cnt_sat;
    logic        full;
    abc_t        m;
    logic [31:0] len_m;
    logic [3:0]  tail_n;
    logic [31:0] len_tail;
    logic        go;

    // the held transaction moves on unless it is a last block and the final stage is full
    assign go        = vld_reg && (!last_reg || fin_ready);
    assign in_stall  = vld_reg && !go;
    assign fin_valid = vld_reg && last_reg;

    // block absorption and tail addition
    always_comb
    begin
        if (in_key_reg)
        begin
            base     = acc_reg;
            base_len = len_reg;
        end
        else
        begin
            base.a   = GOLDEN_RATIO;
            base.b   = GOLDEN_RATIO;
            base.c   = seed;
            base_len = 32'd0;
        end
        cnt_sat = (cnt_reg > BLOCK_BYTES) ? BLOCK_BYTES : cnt_reg;
        full    = !last_reg || (cnt_sat == BLOCK_BYTES);
        sum.a   = base.a + w0_reg;
        sum.b   = base.b + w1_reg;
        sum.c   = base.c + w2_reg;
        mixed   = mix3(sum);
        if (full)
        begin
            m     = mixed;
            len_m = base_len + BLOCK_LEN;
        end
        else
        begin
            m     = base;
            len_m = base_len;
        end
        tail_n     = full ? 4'd0 : cnt_sat;
        len_tail   = len_m + {28'd0, tail_n};
        fin_data.a = m.a + (w0_reg & lane_mask(tail_n, 4'd0));
        fin_data.b = m.b + (w1_reg & lane_mask(tail_n, 4'd4));
        fin_data.c = m.c + len_tail + ((w2_reg & lane_mask(tail_n, 4'd8)) << 8);
    end

    // next accumulator state
    always_comb
    begin
        acc_next    = acc_reg;
        len_next    = len_reg;
        in_key_next = in_key_reg;
        if (go)
        begin
            if (last_reg)
            begin
                in_key_next = 1'b0;
            end
            else
            begin
                acc_next    = mixed;
                len_next    = len_m;
                in_key_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= 1'b0;
            in_key_reg <= 1'b0;
        end
        else
        begin
            in_key_reg <= in_key_next;
            if (!in_stall)
            begin
                vld_reg <= in_valid;
            end
        end
    end

    // input register and accumulators
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        len_reg <= len_next;
        if (in_valid && !in_stall)
        begin
            w0_reg   <= word0;
            w1_reg   <= word1;
            w2_reg   <= word2;
            cnt_reg  <= byte_count;
            last_reg <= last;
        end
    end

endmodule

FILE: hdl/l2bh_final.sv
// final mix stage and hash output register
`include "lookup2_block_hash_top_macros.svh"

module l2bh_final
    import l2bh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fin_valid,
    input  abc_t        fin_data,
    output logic        fin_ready,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] hash
);

    logic        fin_vld_reg;
    abc_t        fin_reg;
    logic        out_valid_reg;
    logic [31:0] hash_reg;
    logic [31:0] hash_next;
    logic        out_ready;
    abc_t        fin_mixed;

    assign out_ready = !out_valid_reg || !out_stall;
    assign fin_ready = !fin_vld_reg || out_ready;
    assign fin_mixed = mix3(fin_reg);
    assign hash_next = fin_mixed.c;
    assign out_valid = out_valid_reg;
    assign hash      = hash_reg;

    // valid flags of the two stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fin_ready)
            begin
                fin_vld_reg <= fin_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= fin_vld_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (fin_valid && fin_ready)
        begin
            fin_reg <= fin_data;
        end
        if (fin_vld_reg && out_ready)
        begin
            hash_reg <= hash_next;
        end
    end

    // checks on the stage hand-off
    `L2BH_ASSERT_NEXT(a_fin_hold, fin_vld_reg && !out_ready, fin_vld_reg && $stable(fin_reg), "final stage lost its transaction")
    `L2BH_ASSERT(a_out_src, $rose(out_valid_reg) |-> $past(fin_vld_reg), "hash appeared without a final stage transaction")
    `L2BH_ASSERT(a_fin_full, !fin_ready |-> (fin_vld_reg && out_valid_reg && out_stall), "final stage refused while room was free")

endmodule

FILE: hdl/lookup2_block_hash_top.sv
// lookup2 block hash top level: seed register and stage wiring
// path: the input register, the final stage register and the hash output register lie between input and hash
// throughput: one 12-byte block per cycle while in_stall is low, set by the accumulator loop through one mix
// the final mix of a key sits in its own stage, so keys may follow each other directly
// reset: rst_n asynchronous active low, clears all valid flags, the key flag and the seed
module lookup2_block_hash_top
    import l2bh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] word0,
    input  logic [31:0] word1,
    input  logic [31:0] word2,
    input  logic [3:0]  byte_count,
    input  logic        last,
    input  logic        in_valid,
    output logic        in_stall,
    output logic [31:0] hash,
    output logic        out_valid,
    input  logic        out_stall,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic [31:0] seed_reg;
    logic        fin_valid;
    logic        fin_ready;
    abc_t        fin_data;

    assign cfg_ready = 1'b1;

    // seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            seed_reg <= cfg_data;
        end
    end

    // block absorption
    l2bh_absorb u_absorb (
        .clk        (clk),
        .rst_n      (rst_n),
        .word0      (word0),
        .word1      (word1),
        .word2      (word2),
        .byte_count (byte_count),
        .last       (last),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .seed       (seed_reg),
        .fin_valid  (fin_valid),
        .fin_data   (fin_data),
        .fin_ready  (fin_ready)
    );

    // final mix and output
    l2bh_final u_final (
        .clk        (clk),
        .rst_n      (rst_n),
        .fin_valid  (fin_valid),
        .fin_data   (fin_data),
        .fin_ready  (fin_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash       (hash)
    );

endmodule

FILE: test/tb_lookup2_block_hash_top.sv
// testbench for the lookup2 block hash: random keys checked against a local hash predictor
module tb_lookup2_block_hash_top;
    timeunit 1ns;
    timeprecision 1ps;

    import l2bh_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int IDLE_LIMIT     = 3000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int SQUEEZE_CYCLES = 150;
    localparam int MAX_GAP        = 17;

    // one 12-byte block of a key as it is offered to the block
    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [3:0]  count;
        logic        last;
    } key_block_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic [31:0] word0      = '0;
    logic [31:0] word1      = '0;
    logic [31:0] word2      = '0;
    logic [3:0]  byte_count = '0;
    logic        last       = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [31:0] hash;
    logic        out_valid;
    logic        out_stall  = 1'b1;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data   = '0;

    // predictor state: seed copy, accumulators and running key length
    logic [31:0] seed_reg  = '0;
    logic [31:0] acc_a     = GOLDEN_RATIO;
    logic [31:0] acc_b     = GOLDEN_RATIO;
    logic [31:0] acc_c     = '0;
    logic [31:0] key_bytes = '0;
    bit          key_open  = 1'b0;

    key_block_t  block_q[$];
    logic [31:0] hash_q[$];
    int          fail_count  = 0;
    bit          in_burst    = 1'b0;
    bit          out_burst   = 1'b0;
    bit          force_burst = 1'b0;
    bit          squeeze     = 1'b0;

    lookup2_block_hash_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .word0      (word0),
        .word1      (word1),
        .word2      (word2),
        .byte_count (byte_count),
        .last       (last),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .hash       (hash),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    // clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // one step of the mix: subtract the other two, then fold in a shifted term
    function automatic logic [31:0] churn(input logic [31:0] x, y, z, fold);
        return (x - y - z) ^ fold;
    endfunction

    function automatic void scramble(inout logic [31:0] a, b, c);
        a = churn(a, b, c, c >> 13);
        b = churn(b, c, a, a << 8);
        c = churn(c, a, b, b >> 13);
        a = churn(a, b, c, c >> 12);
        b = churn(b, c, a, a << 16);
        c = churn(c, a, b, b >> 5);
        a = churn(a, b, c, c >> 3);
        b = churn(b, c, a, a << 10);
        c = churn(c, a, b, b >> 15);
    endfunction

    // low n bytes of a word, n clamped to 0..4
    function automatic logic [31:0] keep_low_bytes(input int n);
        if (n <= 0)
            return 32'h0000_0000;
        if (n >= 4)
            return 32'hffff_ffff;
        return (32'h1 << (8 * n)) - 32'h1;
    endfunction

    function automatic void absorb_block(input key_block_t blk);
        acc_a += blk.w0;
        acc_b += blk.w1;
        acc_c += blk.w2;
        scramble(acc_a, acc_b, acc_c);
        key_bytes += BLOCK_LEN;
    endfunction

    // advances the hash state by one block; returns 1 with the hash when a key ends
    function automatic bit hash_predict(input key_block_t blk, output logic [31:0] h);
        int n;
        n = (blk.count > BLOCK_BYTES) ? int'(BLOCK_BYTES) : int'(blk.count);
        h = '0;
        // a new key reloads the accumulators and picks up the current seed
        if (!key_open)
        begin
            acc_a     = GOLDEN_RATIO;
            acc_b     = GOLDEN_RATIO;
            acc_c     = seed_reg;
            key_bytes = '0;
            key_open  = 1'b1;
        end
        if (!blk.last)
        begin
            absorb_block(blk);
            return 1'b0;
        end
        // a full final block is absorbed first and leaves an empty tail
        if (n == int'(BLOCK_BYTES))
        begin
            absorb_block(blk);
            n = 0;
        end
        key_bytes += n;
        acc_c += key_bytes;
        acc_a += blk.w0 & keep_low_bytes(n);
        acc_b += blk.w1 & keep_low_bytes(n - 4);
        acc_c += (blk.w2 & keep_low_bytes(n - 8)) << 8;
        scramble(acc_a, acc_b, acc_c);
        h = acc_c;
        key_open = 1'b0;
        return 1'b1;
    endfunction

    // driver: offers queued blocks, random gap after each transaction
    key_block_t  cur_block;
    int          in_gap = 0;
    bit          in_busy = 1'b0;
    logic [31:0] predicted;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
            in_busy = 1'b0;
        end
        else
        begin
            in_busy = in_valid;
            // transaction taken at this edge
            if (in_valid && !in_stall)
            begin
                if (hash_predict(cur_block, predicted))
                    hash_q.push_back(predicted);
                in_busy = 1'b0;
            end
            // load the next block once the gap has run out
            if (!in_busy)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (block_q.size() > 0)
                begin
                    cur_block = block_q.pop_front();
                    word0      <= cur_block.w0;
                    word1      <= cur_block.w1;
                    word2      <= cur_block.w2;
                    byte_count <= cur_block.count;
                    last       <= cur_block.last;
                    in_busy = 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        in_burst = !in_burst;
                    in_gap = (in_burst || force_burst) ? 0 : $urandom_range(0, MAX_GAP);
                end
            end
            in_valid <= in_busy;
        end
    end

    // monitor: checks each hash against the oldest prediction, stalls at random
    int          out_gap   = 0;
    int          hold_left = 0;
    bit          squeezed  = 1'b0;
    logic [31:0] want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b1;
            out_gap = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (hash_q.size() == 0)
                begin
                    $error("hash: no result expected, got %08h", hash);
                    fail_count++;
                end
                else
                begin
                    want = hash_q.pop_front();
                    if (hash !== want)
                    begin
                        $error("hash: expected %08h, got %08h", want, hash);
                        fail_count++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    out_burst = !out_burst;
                out_gap = out_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            // single long hold-off so the pipeline fills and back-pressures the input
            if (squeeze && !squeezed)
            begin
                hold_left = SQUEEZE_CYCLES;
                squeezed = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog on cycles without any transaction
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void push_block(input logic [31:0] w0, w1, w2,
                                       input logic [3:0] count, input logic is_last);
        key_block_t blk;
        blk.w0    = w0;
        blk.w1    = w1;
        blk.w2    = w2;
        blk.count = count;
        blk.last  = is_last;
        block_q.push_back(blk);
    endfunction

    // random keys, mostly short with the odd long one
    function automatic void add_keys(input int budget, input int longest, input bit leave_open);
        int len;
        while (budget > 0)
        begin
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(1, longest);
            else
                len = $urandom_range(1, (longest < 4) ? longest : 4);
            for (int i = 0; i < len; i++)
                push_block($urandom, $urandom, $urandom, 4'($urandom_range(0, 15)),
                           i == len - 1);
            budget -= len;
        end
        // unfinished key carried over a seed write
        if (leave_open)
        begin
            push_block($urandom, $urandom, $urandom, 4'($urandom_range(0, 15)), 1'b0);
            push_block($urandom, $urandom, $urandom, 4'($urandom_range(0, 15)), 1'b0);
        end
    endfunction

    // wait for every block to go in and every hash to come out, then let the pipe settle
    task automatic drain();
        while (block_q.size() != 0 || in_busy || hash_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        seed_reg = value;
    endtask

    // directed keys: tail lengths 0 to 12 but 10, saturated counts, ignored counts, full last block
    function automatic void add_directed();
        int tails[12] = '{1, 2, 3, 4, 5, 7, 8, 9, 11, 12, 13, 15};
        push_block(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 4'd0, 1'b1);
        foreach (tails[i])
        begin
            if (i % 3 == 0)
                push_block(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 4'(tails[i]), 1'b1);
            else if (i % 3 == 1)
                push_block(32'h0, 32'h0, 32'h0, 4'(tails[i]), 1'b1);
            else
                push_block($urandom, $urandom, $urandom, 4'(tails[i]), 1'b1);
        end
        push_block(32'h0, 32'h0, 32'h0, 4'd0, 1'b0);
        push_block(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 4'd12, 1'b1);
        push_block(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 4'd15, 1'b0);
        push_block($urandom, $urandom, $urandom, 4'd12, 1'b0);
        push_block($urandom, $urandom, $urandom, 4'd6, 1'b1);
    endfunction

    // test sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed keys under the reset seed
        add_directed();
        drain();

        // all-ones seed, random keys
        write_seed(32'hffff_ffff);
        add_keys(200, 24, 1'b0);
        drain();

        // zero seed, back-to-back single-block keys against a stalled receiver
        write_seed(32'h0000_0000);
        force_burst = 1'b1;
        squeeze = 1'b1;
        add_keys(100, 1, 1'b0);
        drain();
        force_burst = 1'b0;

        // random seed, finishing with a key left open across the next write
        write_seed($urandom);
        add_keys(220, 24, 1'b1);
        drain();

        // new seed only applies from the key after the open one
        write_seed($urandom);
        add_keys(250, 24, 1'b0);
        drain();

        if (fail_count == 0 && hash_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
